>>> src/kmc_pkg.sv
`default_nettype none

package kmc_pkg;

	localparam int MAX_CLUSTERS_DEF = 16;
	localparam int MAX_FEATURES_DEF = 8;
	localparam int MAX_POINTS_DEF   = 1048576;

	localparam int OP_W     = 2;
	localparam int CLUSTER_W = 4;
	localparam int FEATURE_W = 3;
	localparam int VALUE_W  = 16;
	localparam int MEAN_W   = 16;
	localparam int COUNT_W  = 21;
	localparam int STATUS_W = 2;
	localparam int SUM_W    = 40;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam int CC_W       = 5;
	localparam int FC_W       = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_COUNT = 1'd1;

	localparam logic [CC_W-1:0] CLUSTER_COUNT_RST = 5'd16;
	localparam logic [FC_W-1:0] FEATURE_COUNT_RST = 4'd8;

	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_ACC   = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic capture;
		logic commit;
		logic div_start;
		logic div_commit;
	} kmc_cmd_t;

	typedef struct packed {
		logic need_div;
		logic out_free;
		logic div_done;
	} kmc_stat_t;

endpackage

`default_nettype wire

>>> src/kmc_ram.sv
`default_nettype none

module kmc_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> src/kmc_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module kmc_div #(
	parameter int DVS_W = 21
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [kmc_pkg::SUM_W-1:0] dividend,
	input  wire logic [DVS_W-1:0]          divisor,
	output logic                           done,
	output logic      [kmc_pkg::SUM_W-1:0] quotient
);

	localparam int N_W = $clog2(kmc_pkg::SUM_W + 1);

	logic [N_W-1:0]              cnt_q;
	logic                        done_q;
	logic [kmc_pkg::SUM_W-1:0]   quo_q;
	logic [DVS_W-1:0]            rem_q;
	logic [DVS_W-1:0]            dvs_q;
	logic [DVS_W:0]              rem_sh;
	logic [DVS_W:0]              rem_sub;
	logic                        ge;

	always_comb begin
		rem_sh  = {rem_q, quo_q[kmc_pkg::SUM_W-1]};
		ge      = rem_sh >= {1'b0, dvs_q};
		rem_sub = rem_sh - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= N_W'(kmc_pkg::SUM_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - N_W'(1);
			if (cnt_q == N_W'(1)) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[kmc_pkg::SUM_W-2:0], ge};
			rem_q <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

>>> src/kmc_datapath.sv
`default_nettype none

module kmc_datapath #(
	parameter int MAX_CLUSTERS = kmc_pkg::MAX_CLUSTERS_DEF,
	parameter int MAX_FEATURES = kmc_pkg::MAX_FEATURES_DEF,
	parameter int MAX_POINTS   = kmc_pkg::MAX_POINTS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire kmc_pkg::kmc_cmd_t                   cmd,
	output kmc_pkg::kmc_stat_t                       stat,
	input  wire logic                                cfg_we,
	input  wire logic [kmc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [kmc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic [kmc_pkg::OP_W-1:0]            operation,
	input  wire logic [kmc_pkg::CLUSTER_W-1:0]       cluster,
	input  wire logic [kmc_pkg::FEATURE_W-1:0]       feature,
	input  wire logic signed [kmc_pkg::VALUE_W-1:0]  value,
	input  wire logic                                point_end,
	input  wire logic                                out_ready,
	output logic                                     out_valid,
	output logic signed [kmc_pkg::MEAN_W-1:0]        mean,
	output logic      [kmc_pkg::COUNT_W-1:0]         member_count,
	output logic      [kmc_pkg::STATUS_W-1:0]        status
);

	localparam int DEPTH = MAX_CLUSTERS * MAX_FEATURES;
	localparam int AW    = $clog2(DEPTH);
	localparam int CLW   = $clog2(MAX_CLUSTERS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int SW    = kmc_pkg::SUM_W;

	localparam logic signed [SW:0] SUM_MAX = {2'b00, {(SW-1){1'b1}}};
	localparam logic signed [SW:0] SUM_MIN = {2'b11, {(SW-1){1'b0}}};

	// configuration
	logic [kmc_pkg::CC_W-1:0] cluster_count_q;
	logic [kmc_pkg::FC_W-1:0] feature_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_count_q <= kmc_pkg::CLUSTER_COUNT_RST;
			feature_count_q <= kmc_pkg::FEATURE_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				kmc_pkg::CFG_CLUSTER_COUNT: cluster_count_q <= cfg_data;
				kmc_pkg::CFG_FEATURE_COUNT: feature_count_q <= cfg_data[kmc_pkg::FC_W-1:0];
				default: ;
			endcase
		end
	end

	// captured item
	logic [kmc_pkg::OP_W-1:0]           op_q;
	logic [kmc_pkg::CLUSTER_W-1:0]      cl_q;
	logic [kmc_pkg::FEATURE_W-1:0]      ft_q;
	logic signed [kmc_pkg::VALUE_W-1:0] val_q;
	logic                               end_q;
	logic [AW-1:0]                      addr_q;

	logic [31:0] addr_full;
	logic [AW-1:0] addr_in;

	assign addr_full = 32'(cluster) * 32'(MAX_FEATURES) + 32'(feature);
	assign addr_in   = addr_full[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= operation;
			cl_q   <= cluster;
			ft_q   <= feature;
			val_q  <= value;
			end_q  <= point_end;
			addr_q <= addr_in;
		end
	end

	// sum store; an entry without its valid bit reads as zero
	logic [DEPTH-1:0]  vld_q;
	logic [SW-1:0]     ram_rdata;
	logic              ram_we;
	logic signed [SW-1:0] sum_wr;

	kmc_ram #(
		.WIDTH (SW),
		.DEPTH (DEPTH)
	) u_sums (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (sum_wr),
		.re    (cmd.capture),
		.raddr (addr_in),
		.rdata (ram_rdata)
	);

	logic [CNT_W-1:0] counts_q [MAX_CLUSTERS];

	logic [31:0]          cl_ext;
	logic [CLW-1:0]       cl_ix;
	logic                 ok;
	logic signed [SW-1:0] sum_cur;
	logic signed [SW:0]   sum_ext;
	logic [CNT_W-1:0]     cnt_cur;
	logic [CNT_W-1:0]     cnt_new;
	logic                 is_acc;
	logic                 is_clear;

	assign cl_ext = 32'(cl_q);
	assign cl_ix  = cl_ext[CLW-1:0];

	always_comb begin
		ok = (5'(cl_q) < cluster_count_q) && (32'(cl_q) < 32'(MAX_CLUSTERS)) &&
		     (4'(ft_q) < feature_count_q) && (32'(ft_q) < 32'(MAX_FEATURES));
		sum_cur = vld_q[addr_q] ? ram_rdata : '0;
		sum_ext = (SW+1)'(sum_cur) + (SW+1)'(val_q);
		if (sum_ext > SUM_MAX) begin
			sum_wr = SUM_MAX[SW-1:0];
		end else if (sum_ext < SUM_MIN) begin
			sum_wr = SUM_MIN[SW-1:0];
		end else begin
			sum_wr = sum_ext[SW-1:0];
		end
		cnt_cur = counts_q[cl_ix];
		cnt_new = (end_q && cnt_cur < CNT_W'(MAX_POINTS)) ? cnt_cur + CNT_W'(1) : cnt_cur;
		is_acc   = (op_q == kmc_pkg::OP_ACC) && ok;
		is_clear = op_q == kmc_pkg::OP_CLEAR;
	end

	assign ram_we = cmd.commit && is_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			for (int i = 0; i < MAX_CLUSTERS; i++) begin
				counts_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			if (is_clear) begin
				vld_q <= '0;
				for (int i = 0; i < MAX_CLUSTERS; i++) begin
					counts_q[i] <= '0;
				end
			end else if (is_acc) begin
				vld_q[addr_q]   <= 1'b1;
				counts_q[cl_ix] <= cnt_new;
			end
		end
	end

	// mean of a nonempty cluster
	logic [SW-1:0]    mag;
	logic [SW-1:0]    quo;
	logic             div_done;
	logic             neg_q;
	logic [CNT_W-1:0] n_q;

	assign mag = sum_cur[SW-1] ? SW'(-sum_cur) : sum_cur;

	kmc_div #(
		.DVS_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (mag),
		.divisor  (cnt_cur),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			neg_q <= sum_cur[SW-1];
			n_q   <= cnt_cur;
		end
	end

	logic signed [kmc_pkg::MEAN_W-1:0] mean_div;

	always_comb begin
		if (neg_q) begin
			mean_div = (quo > SW'(32768)) ? 16'sh8000 : -quo[kmc_pkg::MEAN_W-1:0];
		end else begin
			mean_div = (quo > SW'(32767)) ? 16'sh7fff : quo[kmc_pkg::MEAN_W-1:0];
		end
	end

	// output register
	logic                              out_valid_q;
	logic signed [kmc_pkg::MEAN_W-1:0] mean_q;
	logic [CNT_W-1:0]                  count_q;
	logic [kmc_pkg::STATUS_W-1:0]      status_q;
	logic [31:0]                       count_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit || cmd.div_commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_commit) begin
			mean_q   <= mean_div;
			count_q  <= n_q;
			status_q <= kmc_pkg::STATUS_OK;
		end else if (cmd.commit) begin
			mean_q  <= '0;
			count_q <= '0;
			if (is_clear) begin
				status_q <= kmc_pkg::STATUS_OK;
			end else if (!ok || op_q != kmc_pkg::OP_ACC && op_q != kmc_pkg::OP_READ) begin
				status_q <= kmc_pkg::STATUS_RANGE;
			end else if (op_q == kmc_pkg::OP_ACC) begin
				count_q  <= cnt_new;
				status_q <= kmc_pkg::STATUS_OK;
			end else begin
				status_q <= kmc_pkg::STATUS_EMPTY;
			end
		end
	end

	assign count_ext    = 32'(count_q);
	assign out_valid    = out_valid_q;
	assign mean         = mean_q;
	assign member_count = count_ext[kmc_pkg::COUNT_W-1:0];
	assign status       = status_q;

	assign stat.need_div = (op_q == kmc_pkg::OP_READ) && ok && (cnt_cur != '0);
	assign stat.out_free = !out_valid_q || out_ready;
	assign stat.div_done = div_done;

endmodule

`default_nettype wire

>>> src/kmc_ctrl.sv
`default_nettype none

module kmc_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire kmc_pkg::kmc_stat_t stat,
	output kmc_pkg::kmc_cmd_t       cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOOK = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nx;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nx    = S_LOOK;
				end
			end
			S_LOOK: begin
				if (stat.need_div) begin
					cmd.div_start = 1'b1;
					state_nx      = S_DIV;
				end else if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_nx   = S_IDLE;
				end
			end
			S_DIV: begin
				if (stat.div_done && stat.out_free) begin
					cmd.div_commit = 1'b1;
					state_nx       = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.commit, cmd.div_start, cmd.div_commit}))
		else $error("more than one command at once");

	a_capture_look: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == S_LOOK)
		else $error("capture not followed by lookup");

	a_start_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> state_q == S_DIV && !stat.div_done)
		else $error("divider start not seen");

	a_div_commit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_commit |-> $past(state_q) == S_DIV && stat.out_free)
		else $error("divide result committed out of order");

endmodule

`default_nettype wire

>>> src/kmeans_centroid_update.sv
`default_nettype none

// k-means centroid accumulator: per-cluster feature sums (40-bit, saturating) and member
// counts, with a mean read. For clear, accumulate and rejected items the accept cycle
// reads the sum memory through its single registered read port, and the update follows
// in the lookup state once the output register is free. A read of a nonempty cluster runs
// the bit-serial restoring divider, which produces one of 40 quotient bits per cycle.
// Clear takes effect at once through per-entry valid bits; no clearing pass follows reset.
// A new item is accepted while the previous result still sits in the output register; the
// block stalls only when that register is still full at the moment the next result is ready.
module kmeans_centroid_update #(
	parameter int MAX_CLUSTERS = kmc_pkg::MAX_CLUSTERS_DEF,
	parameter int MAX_FEATURES = kmc_pkg::MAX_FEATURES_DEF,
	parameter int MAX_POINTS   = kmc_pkg::MAX_POINTS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [kmc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [kmc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [kmc_pkg::OP_W-1:0]            operation,
	input  wire logic [kmc_pkg::CLUSTER_W-1:0]       cluster,
	input  wire logic [kmc_pkg::FEATURE_W-1:0]       feature,
	input  wire logic signed [kmc_pkg::VALUE_W-1:0]  value,
	input  wire logic                                point_end,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [kmc_pkg::MEAN_W-1:0]        mean,
	output logic      [kmc_pkg::COUNT_W-1:0]         member_count,
	output logic      [kmc_pkg::STATUS_W-1:0]        status
);

	kmc_pkg::kmc_cmd_t  cmd;
	kmc_pkg::kmc_stat_t stat;

	kmc_datapath #(
		.MAX_CLUSTERS (MAX_CLUSTERS),
		.MAX_FEATURES (MAX_FEATURES),
		.MAX_POINTS   (MAX_POINTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.operation    (operation),
		.cluster      (cluster),
		.feature      (feature),
		.value        (value),
		.point_end    (point_end),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.mean         (mean),
		.member_count (member_count),
		.status       (status)
	);

	kmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

endmodule

`default_nettype wire
